FILE: src/hdlc_byte_unstuff_deframer_top_assert.svh
// Assertion macros shared by the deframer RTL.
// Depends on nothing; users supply i_clk and i_rst_n in scope.
`ifndef HDLC_BYTE_UNSTUFF_DEFRAMER_TOP_ASSERT_SVH
`define HDLC_BYTE_UNSTUFF_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HDLCUD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HDLCUD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

FILE: src/hdlcud_pkg.sv
// Package for the HDLC byte-unstuffing deframer: types, register map, status codes.
// No dependencies.
package hdlcud_pkg;

    localparam int MTU_LIMIT_DEF = 4095;

    localparam int BYTE_W  = 8;
    localparam int FRAME_W = 12;
    localparam int COUNT_W = 13;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_MAX_FRAME   = 3'd0;
    localparam logic [2:0] REG_MIN_HEADER  = 3'd1;
    localparam logic [2:0] REG_FLAG_BYTE   = 3'd2;
    localparam logic [2:0] REG_ESCAPE_BYTE = 3'd3;
    localparam logic [2:0] REG_ESCAPE_MASK = 3'd4;

    localparam logic [FRAME_W-1:0] RST_MAX_FRAME   = 12'd500;
    localparam logic [BYTE_W-1:0]  RST_MIN_HEADER  = 8'd19;
    localparam logic [BYTE_W-1:0]  RST_FLAG_BYTE   = 8'd126;
    localparam logic [BYTE_W-1:0]  RST_ESCAPE_BYTE = 8'd125;
    localparam logic [BYTE_W-1:0]  RST_ESCAPE_MASK = 8'd32;

    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_SHORT    = 3'd1,
        ST_LONG     = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_ABORT    = 3'd4
    } t_status;

    typedef struct packed {
        logic [FRAME_W-1:0] max_frame;
        logic [BYTE_W-1:0]  min_header;
        logic [BYTE_W-1:0]  flag_byte;
        logic [BYTE_W-1:0]  escape_byte;
        logic [BYTE_W-1:0]  escape_mask;
    } t_cfg;

endpackage

FILE: src/hdlc_byte_unstuff_deframer_top.sv
// Path: an accepted item lands in the input register; its result (if any) goes to the result
// register once the result side is free. Throughput: one item per cycle unless the output
// stalls; the frame-state update is a single compare/increment pass.
// Items that cause no result (bytes outside a frame, escapes, empty closes) just retire.
// Reset (i_rst_n low, synchronous): frame state cleared, both pipeline stages empty,
// configuration registers return to their defaults (MTU 500, header 19, 0x7E/0x7D/0x20).
// Depends on hdlcud_pkg, hdlcud_regs, hdlcud_core.
module hdlc_byte_unstuff_deframer_top #(
    parameter int MTU_LIMIT = hdlcud_pkg::MTU_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hdlcud_pkg::ADDR_W-1:0]   paddr,
    input  logic [hdlcud_pkg::DATA_W-1:0]   pwdata,
    output logic [hdlcud_pkg::DATA_W-1:0]   prdata,
    output logic                            pready,
    // received item channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [hdlcud_pkg::BYTE_W-1:0]   i_rx_byte,
    // result item channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [hdlcud_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                            o_end_of_frame,
    output logic [2:0]                      o_frame_status,
    output logic [hdlcud_pkg::COUNT_W-1:0]  o_frame_length
);

    // live configuration; software must change it only while the pipe is idle (not enforced here)
    hdlcud_pkg::t_cfg cfg;

    hdlcud_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // input register -> flag/escape decode + count update -> result register
    hdlcud_core #(
        .MTU_LIMIT (MTU_LIMIT)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_end_of_frame (o_end_of_frame),
        .o_frame_status (o_frame_status),
        .o_frame_length (o_frame_length)
    );

endmodule

FILE: src/hdlcud_regs.sv
// APB-style configuration registers for the deframer.
// Depends on hdlcud_pkg.
module hdlcud_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hdlcud_pkg::ADDR_W-1:0]  paddr,
    input  logic [hdlcud_pkg::DATA_W-1:0]  pwdata,
    output logic [hdlcud_pkg::DATA_W-1:0]  prdata,
    output logic                           pready,
    output hdlcud_pkg::t_cfg               o_cfg
);

    hdlcud_pkg::t_cfg r_cfg;
    logic             wr_en;
    logic [2:0]       reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_frame   <= hdlcud_pkg::RST_MAX_FRAME;
            r_cfg.min_header  <= hdlcud_pkg::RST_MIN_HEADER;
            r_cfg.flag_byte   <= hdlcud_pkg::RST_FLAG_BYTE;
            r_cfg.escape_byte <= hdlcud_pkg::RST_ESCAPE_BYTE;
            r_cfg.escape_mask <= hdlcud_pkg::RST_ESCAPE_MASK;
        end else if (wr_en) begin
            case (reg_idx)
                hdlcud_pkg::REG_MAX_FRAME:
                    r_cfg.max_frame <= pwdata[hdlcud_pkg::FRAME_W-1:0];
                hdlcud_pkg::REG_MIN_HEADER:
                    r_cfg.min_header <= pwdata[hdlcud_pkg::BYTE_W-1:0];
                hdlcud_pkg::REG_FLAG_BYTE:
                    r_cfg.flag_byte <= pwdata[hdlcud_pkg::BYTE_W-1:0];
                hdlcud_pkg::REG_ESCAPE_BYTE:
                    r_cfg.escape_byte <= pwdata[hdlcud_pkg::BYTE_W-1:0];
                hdlcud_pkg::REG_ESCAPE_MASK:
                    r_cfg.escape_mask <= pwdata[hdlcud_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            hdlcud_pkg::REG_MAX_FRAME:   prdata = 32'(r_cfg.max_frame);
            hdlcud_pkg::REG_MIN_HEADER:  prdata = 32'(r_cfg.min_header);
            hdlcud_pkg::REG_FLAG_BYTE:   prdata = 32'(r_cfg.flag_byte);
            hdlcud_pkg::REG_ESCAPE_BYTE: prdata = 32'(r_cfg.escape_byte);
            hdlcud_pkg::REG_ESCAPE_MASK: prdata = 32'(r_cfg.escape_mask);
            default:                     prdata = '0;
        endcase
    end

endmodule

FILE: src/hdlcud_core.sv
// Deframer datapath: input register, frame state, result register.
// Depends on hdlcud_pkg and hdlc_byte_unstuff_deframer_top_assert.svh.
`include "hdlc_byte_unstuff_deframer_top_assert.svh"

module hdlcud_core #(
    parameter int MTU_LIMIT = hdlcud_pkg::MTU_LIMIT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  hdlcud_pkg::t_cfg                i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_req_type,
    input  logic [hdlcud_pkg::BYTE_W-1:0]   i_rx_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [hdlcud_pkg::BYTE_W-1:0]   o_out_byte,
    output logic                            o_end_of_frame,
    output logic [2:0]                      o_frame_status,
    output logic [hdlcud_pkg::COUNT_W-1:0]  o_frame_length
);

    localparam int FW = hdlcud_pkg::FRAME_W;
    localparam int CW = hdlcud_pkg::COUNT_W;
    localparam int BW = hdlcud_pkg::BYTE_W;
    // MTU cap folded to the register width
    localparam logic [FW-1:0] MtuCap =
        (MTU_LIMIT >= (1 << FW) - 1) ? {FW{1'b1}} : FW'(MTU_LIMIT);

    // input register
    logic          r_in_valid;
    logic          r_in_req;
    logic [BW-1:0] r_in_byte;

    // frame state
    logic          r_in_frame, n_in_frame;
    logic          r_esc, n_esc;
    logic [CW-1:0] r_count, n_count;

    // result register
    logic          r_out_valid;
    logic [BW-1:0] r_out_byte, n_out_byte;
    logic          r_out_eof, n_out_eof;
    logic [2:0]    r_out_status, n_out_status;
    logic [CW-1:0] r_out_len, n_out_len;
    logic          n_has_res;

    logic          out_free;
    logic          fire;
    logic [FW-1:0] mtu;
    logic [CW-1:0] lim;
    logic          nonempty;
    logic [BW-1:0] data_byte;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    assign mtu       = (i_cfg.max_frame > MtuCap) ? MtuCap : i_cfg.max_frame;
    assign lim       = {mtu, 1'b0};
    assign nonempty  = r_in_frame && (r_count != '0);
    assign data_byte = r_esc ? (r_in_byte ^ i_cfg.escape_mask) : r_in_byte;

    always_comb begin
        n_in_frame   = r_in_frame;
        n_esc        = r_esc;
        n_count      = r_count;
        n_has_res    = 1'b0;
        n_out_byte   = '0;
        n_out_eof    = 1'b1;
        n_out_status = hdlcud_pkg::ST_GOOD;
        n_out_len    = r_count;
        if (r_in_req) begin
            // link drop
            n_has_res    = nonempty;
            n_out_status = hdlcud_pkg::ST_ABORT;
            n_in_frame   = 1'b0;
            n_esc        = 1'b0;
            n_count      = '0;
        end else if (r_in_byte == i_cfg.flag_byte) begin
            n_has_res = nonempty;
            if (r_count <= CW'(i_cfg.min_header)) begin
                n_out_status = hdlcud_pkg::ST_SHORT;
            end else if (r_count > CW'(mtu)) begin
                n_out_status = hdlcud_pkg::ST_LONG;
            end else begin
                n_out_status = hdlcud_pkg::ST_GOOD;
            end
            n_in_frame = 1'b1;
            n_esc      = 1'b0;
            n_count    = '0;
        end else if (!r_in_frame) begin
            n_has_res = 1'b0;
        end else if (r_in_byte == i_cfg.escape_byte) begin
            n_esc = 1'b1;
        end else if (r_count < lim) begin
            n_esc        = 1'b0;
            n_count      = r_count + 1'b1;
            n_has_res    = 1'b1;
            n_out_byte   = data_byte;
            n_out_eof    = 1'b0;
            n_out_status = hdlcud_pkg::ST_GOOD;
            n_out_len    = '0;
        end else begin
            // frame ran past twice the MTU: close it and resync on next flag
            n_esc        = 1'b0;
            n_has_res    = 1'b1;
            n_out_status = hdlcud_pkg::ST_OVERFLOW;
            n_in_frame   = 1'b0;
            n_count      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_in_frame  <= 1'b0;
            r_esc       <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_in_frame <= n_in_frame;
                r_esc      <= n_esc;
                r_count    <= n_count;
            end
            if (out_free) begin
                r_out_valid <= fire && n_has_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_req  <= i_req_type;
            r_in_byte <= i_rx_byte;
        end
        if (fire && n_has_res) begin
            r_out_byte   <= n_out_byte;
            r_out_eof    <= n_out_eof;
            r_out_status <= n_out_status;
            r_out_len    <= n_out_len;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_end_of_frame = r_out_eof;
    assign o_frame_status = r_out_status;
    assign o_frame_length = r_out_len;

    `HDLCUD_ASSERT_IMPL(a_count_needs_frame, r_count != '0, r_in_frame)
    `HDLCUD_ASSERT_IMPL(a_payload_clean, r_out_valid && !r_out_eof,
        (r_out_status == hdlcud_pkg::ST_GOOD) && (r_out_len == '0))
    // only an overflow on a zero MTU closes a frame at length zero
    `HDLCUD_ASSERT_IMPL(a_empty_end_overflow, r_out_valid && r_out_eof && (r_out_len == '0),
        r_out_status == hdlcud_pkg::ST_OVERFLOW)
    `HDLCUD_ASSERT_NEXT(a_drop_clears, fire && r_in_req, !r_in_frame && !r_esc && (r_count == '0))

endmodule

FILE: test/hdlc_byte_unstuff_deframer_top_test.sv
// Self-checking bench for the HDLC byte-unstuffing deframer: directed table, then random frames.
// Depends on hdlcud_pkg and hdlc_byte_unstuff_deframer_top; no files or arguments.
module hdlc_byte_unstuff_deframer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    // request codes on i_req_type
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_DROP = 1'b1;

    // default delimiter / escape, used by the directed table
    localparam logic [7:0] FLG = hdlcud_pkg::RST_FLAG_BYTE;
    localparam logic [7:0] ESC = hdlcud_pkg::RST_ESCAPE_BYTE;

    localparam int N_PHASES        = 7;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall to back up the input
    localparam int QUIET_LIMIT     = 4000;  // cycles with no handshake before giving up
    localparam int MAX_FRAME_LO    = 60;    // longest length class start worth sending

    // idle percentages per random phase: sender, receiver
    localparam int SRC_IDLE[N_PHASES] = '{0, 85, 0, 17, 0, 85, 0};
    localparam int RCV_IDLE[N_PHASES] = '{0, 0, 85, 17, 0, 0, 85};

    // one result item as the block presents it
    typedef struct packed {
        logic [7:0]          data;
        logic                eof;
        hdlcud_pkg::t_status status;
        logic [12:0]         len;
    } t_out;

    // directed table row: an input item (with or without a typed-in result) or a register write
    typedef enum logic [1:0] {ROW_NONE, ROW_PRED, ROW_FIXED, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        req;
        logic [7:0]  data;
        t_out        want;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
    } t_row;

    // ---------------------------------------------------------------- DUT signals
    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            psel       = 1'b0;
    logic                            penable    = 1'b0;
    logic                            pwrite     = 1'b0;
    logic [hdlcud_pkg::ADDR_W-1:0]   paddr      = '0;
    logic [hdlcud_pkg::DATA_W-1:0]   pwdata     = '0;
    logic [hdlcud_pkg::DATA_W-1:0]   prdata;
    logic                            pready;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_stall;
    logic                            i_req_type = 1'b0;
    logic [hdlcud_pkg::BYTE_W-1:0]   i_rx_byte  = '0;
    logic                            o_out_valid;
    logic                            i_out_stall = 1'b0;
    logic [hdlcud_pkg::BYTE_W-1:0]   o_out_byte;
    logic                            o_end_of_frame;
    logic [2:0]                      o_frame_status;
    logic [hdlcud_pkg::COUNT_W-1:0]  o_frame_length;

    hdlc_byte_unstuff_deframer_top dut (.*);

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor state
    // register shadow, reset values from the package
    logic [11:0] cfg_max_frame  = hdlcud_pkg::RST_MAX_FRAME;
    logic [7:0]  cfg_min_header = hdlcud_pkg::RST_MIN_HEADER;
    logic [7:0]  cfg_flag       = hdlcud_pkg::RST_FLAG_BYTE;
    logic [7:0]  cfg_escape     = hdlcud_pkg::RST_ESCAPE_BYTE;
    logic [7:0]  cfg_mask       = hdlcud_pkg::RST_ESCAPE_MASK;

    // deframer state
    logic        st_in_frame    = 1'b0;
    logic        st_esc_pending = 1'b0;
    logic [12:0] st_count       = '0;

    t_out frame_out_q[$];   // results still owed by the block, oldest first

    // run-wide bookkeeping
    int errors        = 0;
    int n_items       = 0;
    int n_results     = 0;
    int n_settings    = 0;
    int ends_by_status[5] = '{0, 0, 0, 0, 0};
    int src_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int hold_left     = 0;  // set by stimulus, counted down by the result side
    int quiet_cycles  = 0;

    // MTU actually in force: register value capped at the build limit
    function automatic int eff_mtu();
        int m;
        m = cfg_max_frame;
        if (m > hdlcud_pkg::MTU_LIMIT_DEF)
            m = hdlcud_pkg::MTU_LIMIT_DEF;
        return m;
    endfunction

    // Advance the deframer state by one item; returns 1 when a result is due.
    function automatic bit unstuff_step(input logic req, input logic [7:0] d, output t_out r);
        int mtu;
        mtu = eff_mtu();
        r   = '0;
        if (req == REQ_DROP) begin
            unstuff_step = st_in_frame && (st_count != 0);
            if (unstuff_step)
                r = '{data: '0, eof: 1'b1, status: hdlcud_pkg::ST_ABORT, len: st_count};
            st_in_frame    = 1'b0;
            st_esc_pending = 1'b0;
            st_count       = '0;
            return unstuff_step;
        end
        // flag always wins, even over a pending escape
        if (d == cfg_flag) begin
            unstuff_step = st_in_frame && (st_count != 0);
            if (unstuff_step) begin
                r.eof = 1'b1;
                r.len = st_count;
                if (st_count <= cfg_min_header)
                    r.status = hdlcud_pkg::ST_SHORT;    // short takes priority over long
                else if (int'(st_count) > mtu)
                    r.status = hdlcud_pkg::ST_LONG;
                else
                    r.status = hdlcud_pkg::ST_GOOD;
            end
            st_in_frame    = 1'b1;
            st_esc_pending = 1'b0;
            st_count       = '0;
            return unstuff_step;
        end
        if (!st_in_frame)
            return 1'b0;
        if (d == cfg_escape) begin
            st_esc_pending = 1'b1;
            return 1'b0;
        end
        if (st_esc_pending) begin
            d              = d ^ cfg_mask;
            st_esc_pending = 1'b0;
        end
        if (int'(st_count) < 2 * mtu) begin
            st_count = st_count + 1'b1;
            r.data   = d;
            return 1'b1;
        end
        // past twice the MTU: end the frame, drop until the next flag
        r           = '{data: '0, eof: 1'b1, status: hdlcud_pkg::ST_OVERFLOW, len: st_count};
        st_in_frame = 1'b0;
        st_count    = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- table helpers
    function automatic t_out pay(logic [7:0] d);
        return '{data: d, eof: 1'b0, status: hdlcud_pkg::ST_GOOD, len: '0};
    endfunction

    function automatic t_out fin(hdlcud_pkg::t_status s, int unsigned n);
        return '{data: '0, eof: 1'b1, status: s, len: n[12:0]};
    endfunction

    function automatic t_row item_row(t_row_kind k, logic rq, logic [7:0] d, t_out w = '0);
        return '{kind: k, req: rq, data: d, want: w, reg_idx: '0, reg_val: '0};
    endfunction

    function automatic t_row reg_row(logic [2:0] idx, logic [31:0] v);
        return '{kind: ROW_CFG, req: REQ_BYTE, data: '0, want: '0, reg_idx: idx, reg_val: v};
    endfunction

    function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    // ---------------------------------------------------------------- drivers
    // Offer one item, wait for it to be taken, then log what the block owes for it.
    task automatic send_item(input logic req, input logic [7:0] d,
                             input t_row_kind kind = ROW_PRED, input t_out want = '0);
        t_out pred;
        bit   hit;
        bit   took;
        while ($urandom_range(99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_rx_byte  <= d;
        // stall has settled by mid-cycle and holds up to the next edge
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = (o_in_stall === 1'b0);
            @(posedge i_clk);
        end
        hit = unstuff_step(req, d, pred);
        if (kind == ROW_FIXED)
            frame_out_q.push_back(want);
        else if (kind == ROW_PRED && hit)
            frame_out_q.push_back(pred);
        n_items++;
    endtask

    // Stop offering, let every owed result come out, then cover items still in flight.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (frame_out_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, done on the edge with pready high.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        case (idx)
            hdlcud_pkg::REG_MAX_FRAME:   cfg_max_frame  = val[11:0];
            hdlcud_pkg::REG_MIN_HEADER:  cfg_min_header = val[7:0];
            hdlcud_pkg::REG_FLAG_BYTE:   cfg_flag       = val[7:0];
            hdlcud_pkg::REG_ESCAPE_BYTE: cfg_escape     = val[7:0];
            hdlcud_pkg::REG_ESCAPE_MASK: cfg_mask       = val[7:0];
            default: ;
        endcase
    endtask

    // A stuffed frame: optional opening flag, payload of a length aimed at one
    // status class, closing flag.
    task automatic send_frame();
        int mtu, lo, hi, pick, len;
        logic [7:0] raw;
        mtu  = eff_mtu();
        pick = $urandom_range(99);
        if (pick < 35) begin
            lo = 0;                   hi = cfg_min_header;
        end else if (pick < 75) begin
            lo = cfg_min_header + 1;  hi = mtu;
        end else if (pick < 90) begin
            lo = mtu + 1;             hi = 2 * mtu;
        end else begin
            lo = 2 * mtu + 1;         hi = 2 * mtu + 3;
        end
        // keep frames cheap: fall back to short ones when the class is out of reach
        if (lo > hi || lo > MAX_FRAME_LO) begin
            lo = 0;
            hi = cfg_min_header;
        end
        len = lo + $urandom_range(0, (hi - lo > 40) ? 40 : hi - lo);
        if (!st_in_frame || $urandom_range(4) == 0)
            send_item(REQ_BYTE, cfg_flag);
        for (int k = 0; k < len; k++) begin
            raw = 8'($urandom_range(255));
            if ($urandom_range(99) < 12)
                raw = $urandom_range(1) ? cfg_flag : cfg_escape;
            // stuff the reserved values, and now and then an ordinary byte too
            if (raw == cfg_flag || raw == cfg_escape || $urandom_range(99) < 4) begin
                send_item(REQ_BYTE, cfg_escape);
                send_item(REQ_BYTE, raw ^ cfg_mask);
            end else begin
                send_item(REQ_BYTE, raw);
            end
        end
        send_item(REQ_BYTE, cfg_flag);
    endtask

    // Short burst of junk: link drops, stray bytes, lone flags and escapes.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            case ($urandom_range(4))
                0: send_item(REQ_DROP, 8'($urandom_range(255)));
                1: send_item(REQ_BYTE, 8'($urandom_range(255)));
                2: send_item(REQ_BYTE, cfg_flag);
                3: send_item(REQ_BYTE, cfg_escape);
                default: begin
                    send_item(REQ_BYTE, cfg_escape);
                    send_item(REQ_BYTE, cfg_flag);
                end
            endcase
        end
    endtask

    // ---------------------------------------------------------------- result side
    // Samples the result channel mid-cycle, checks each taken result against the
    // oldest owed one at the edge, then picks the next stall value: forced high
    // during a hold-off, random otherwise.
    initial begin : result_side
        t_out        want;
        bit          took;
        logic [7:0]  s_byte;
        logic        s_eof;
        logic [2:0]  s_status;
        logic [12:0] s_len;
        forever begin
            @(negedge i_clk);
            took     = i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0;
            s_byte   = o_out_byte;
            s_eof    = o_end_of_frame;
            s_status = o_frame_status;
            s_len    = o_frame_length;
            @(posedge i_clk);
            if (took) begin
                if (frame_out_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: byte %0d eof %0d status %0d length %0d",
                             $time, s_byte, s_eof, s_status, s_len);
                end else begin
                    want = frame_out_q.pop_front();
                    check_field("out_byte", want.data, s_byte);
                    check_field("end_of_frame", want.eof, s_eof);
                    check_field("frame_status", want.status, s_status);
                    check_field("frame_length", want.len, s_len);
                    n_results++;
                    if (want.eof)
                        ends_by_status[want.status]++;
                end
            end
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    // Counts cycles in which neither channel moves an item; looks mid-cycle,
    // where the handshake signals have settled for the coming edge.
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_stall === 1'b0)
                || (o_out_valid === 1'b1 && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial begin : stimulus
        t_row dir_rows[$];
        int   phase_end;
        bit   paused;
        int   c_max, c_hdr, c_flag, c_esc, c_mask;

        paused = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, starting from reset settings (MTU 500, header 19).
        dir_rows = '{
            item_row(ROW_NONE,  REQ_BYTE, 8'h00),               // stray byte, no frame
            item_row(ROW_NONE,  REQ_DROP, 8'h00),               // drop while closed
            item_row(ROW_NONE,  REQ_BYTE, FLG),                 // opens a frame
            item_row(ROW_NONE,  REQ_BYTE, FLG),                 // empty frame: silent
            item_row(ROW_FIXED, REQ_BYTE, 8'hFF, pay(8'hFF)),
            item_row(ROW_NONE,  REQ_BYTE, ESC),
            item_row(ROW_NONE,  REQ_BYTE, ESC),                 // second escape just pends
            item_row(ROW_FIXED, REQ_BYTE, 8'h5E, pay(8'h7E)),   // unescaped to the flag value
            item_row(ROW_NONE,  REQ_BYTE, ESC),
            // flag drops the escape
            item_row(ROW_FIXED, REQ_BYTE, FLG, fin(hdlcud_pkg::ST_SHORT, 2)),
            item_row(ROW_FIXED, REQ_BYTE, 8'h00, pay(8'h00)),
            // byte ignored on drop
            item_row(ROW_FIXED, REQ_DROP, FLG, fin(hdlcud_pkg::ST_ABORT, 1)),
            // header 0, MTU 2: good, long
            reg_row(hdlcud_pkg::REG_MIN_HEADER, 0),
            reg_row(hdlcud_pkg::REG_MAX_FRAME, 2),
            item_row(ROW_NONE,  REQ_BYTE, FLG),
            item_row(ROW_PRED,  REQ_BYTE, 8'h0A),
            item_row(ROW_FIXED, REQ_BYTE, FLG, fin(hdlcud_pkg::ST_GOOD, 1)),
            item_row(ROW_PRED,  REQ_BYTE, 8'h01),
            item_row(ROW_PRED,  REQ_BYTE, 8'h02),
            item_row(ROW_PRED,  REQ_BYTE, 8'h03),
            item_row(ROW_FIXED, REQ_BYTE, FLG, fin(hdlcud_pkg::ST_LONG, 3)),
            // zero MTU: first payload byte overflows at length 0
            reg_row(hdlcud_pkg::REG_MAX_FRAME, 0),
            item_row(ROW_FIXED, REQ_BYTE, 8'h55, fin(hdlcud_pkg::ST_OVERFLOW, 0)),
            item_row(ROW_NONE,  REQ_BYTE, 8'h66),               // dropped until next flag
            // MTU 1, header 3: a 2-byte frame is both short and long, short wins
            reg_row(hdlcud_pkg::REG_MAX_FRAME, 1),
            reg_row(hdlcud_pkg::REG_MIN_HEADER, 3),
            item_row(ROW_NONE,  REQ_BYTE, FLG),
            item_row(ROW_PRED,  REQ_BYTE, 8'h01),
            item_row(ROW_PRED,  REQ_BYTE, 8'h02),
            item_row(ROW_FIXED, REQ_BYTE, FLG, fin(hdlcud_pkg::ST_SHORT, 2))
        };
        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_CFG) begin
                wait_drained();
                write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
            end else begin
                send_item(dir_rows[k].req, dir_rows[k].data, dir_rows[k].kind,
                          dir_rows[k].want);
            end
        end

        // Random part: one register setting and one idling pattern per phase.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: begin  // reset defaults, written explicitly
                    c_max  = hdlcud_pkg::RST_MAX_FRAME;
                    c_hdr  = hdlcud_pkg::RST_MIN_HEADER;
                    c_flag = hdlcud_pkg::RST_FLAG_BYTE;
                    c_esc  = hdlcud_pkg::RST_ESCAPE_BYTE;
                    c_mask = hdlcud_pkg::RST_ESCAPE_MASK;
                end
                1: begin  // top of every range
                    c_max = 4095; c_hdr = 255; c_flag = 8'h00; c_esc = 8'hFF; c_mask = 8'hFF;
                end
                2: begin  // bottom of every range
                    c_max = 1; c_hdr = 0; c_flag = 8'hFF; c_esc = 8'h00; c_mask = 8'h00;
                end
                default: begin
                    c_max  = ($urandom_range(3) == 0) ? $urandom_range(1, 4095)
                                                      : $urandom_range(1, 24);
                    c_hdr  = $urandom_range(0, 12);
                    c_flag = $urandom_range(255);
                    c_esc  = $urandom_range(255);
                    c_mask = $urandom_range(255);
                end
            endcase
            // registers change only with nothing in flight
            wait_drained();
            write_reg(hdlcud_pkg::REG_MAX_FRAME, c_max);
            write_reg(hdlcud_pkg::REG_MIN_HEADER, c_hdr);
            write_reg(hdlcud_pkg::REG_FLAG_BYTE, c_flag);
            write_reg(hdlcud_pkg::REG_ESCAPE_BYTE, c_esc);
            write_reg(hdlcud_pkg::REG_ESCAPE_MASK, c_mask);
            n_settings++;

            src_idle_pct  = SRC_IDLE[ph];
            rcv_stall_pct = RCV_IDLE[ph];
            // back up the pipe: receiver frozen while the sender keeps pushing
            if (ph == 0)
                hold_left = HOLD_OFF_CYCLES;

            phase_end = n_items + ITEMS_PER_PHASE;
            while (n_items < phase_end) begin
                // once, mid-phase: sender waits for every owed result
                if (ph == 4 && !paused && n_items > phase_end - ITEMS_PER_PHASE / 2) begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 15)
                    send_noise();
                else
                    send_frame();
            end
        end

        wait_drained();
        $display("Sent %0d items under %0d register settings; %0d results checked",
                 n_items, n_settings, n_results);
        $display("Frame ends good/short/long/overflow/aborted: %0d/%0d/%0d/%0d/%0d",
                 ends_by_status[hdlcud_pkg::ST_GOOD], ends_by_status[hdlcud_pkg::ST_SHORT],
                 ends_by_status[hdlcud_pkg::ST_LONG], ends_by_status[hdlcud_pkg::ST_OVERFLOW],
                 ends_by_status[hdlcud_pkg::ST_ABORT]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/hdlcud_pkg.sv
src/hdlcud_regs.sv
src/hdlcud_core.sv
src/hdlc_byte_unstuff_deframer_top.sv
test/hdlc_byte_unstuff_deframer_top_test.sv
